// File: hw/rtl/sjf_pkg.sv
// Shared types and constants for the shortest-job-first scheduler.
// Depends on nothing; every other file of the block takes names from here.
`timescale 1ns / 1ps
`default_nettype none

package sjf_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int TIME_WIDTH  = 16;
  localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int ID_W        = 8;
  localparam int BURST_W     = 8;
  localparam int OUT_TIME_W  = 16;
  localparam int COUNT_W     = 16;
  localparam int SUM_W       = 32;
  localparam int QCOUNT_W    = 6;

  // command codes of an input word
  localparam logic CMD_ARRIVE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  typedef enum logic [1:0] {
    ST_ACCEPT = 2'd0,
    ST_FULL   = 2'd1,
    ST_ZERO   = 2'd2,
    ST_TICK   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_SHIFT  = 2'd2
  } cell_op_t;

  typedef struct packed {
    logic [ID_W-1:0]       id;
    logic [BURST_W-1:0]    burst;
    logic [TIME_WIDTH-1:0] arrival;
  } job_t;

  typedef struct packed {
    status_t               status;
    logic                  cpu_busy;
    logic [ID_W-1:0]       running_id;
    logic [BURST_W-1:0]    units_done;
    logic                  job_finished;
    logic [OUT_TIME_W-1:0] turnaround;
    logic [OUT_TIME_W-1:0] waiting;
    logic [OUT_TIME_W-1:0] slot_time;
    logic [COUNT_W-1:0]    completed_count;
    logic [SUM_W-1:0]      total_waiting;
    logic [SUM_W-1:0]      total_turnaround;
    logic [QCOUNT_W-1:0]   queue_count;
  } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/sjf_if.sv
// Valid/ready channel interfaces for the scheduler's input and result words.
// Depends on sjf_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface sjf_in_if;
  logic                        valid;
  logic                        ready;
  logic                        command;
  logic [sjf_pkg::ID_W-1:0]    job_id;
  logic [sjf_pkg::BURST_W-1:0] burst_length;

  modport source (output valid, command, job_id, burst_length, input ready);
  modport sink   (input valid, command, job_id, burst_length, output ready);
endinterface

interface sjf_out_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     status;
  logic                           cpu_busy;
  logic [sjf_pkg::ID_W-1:0]       running_id;
  logic [sjf_pkg::BURST_W-1:0]    units_done;
  logic                           job_finished;
  logic [sjf_pkg::OUT_TIME_W-1:0] turnaround;
  logic [sjf_pkg::OUT_TIME_W-1:0] waiting;
  logic [sjf_pkg::OUT_TIME_W-1:0] slot_time;
  logic [sjf_pkg::COUNT_W-1:0]    completed_count;
  logic [sjf_pkg::SUM_W-1:0]      total_waiting;
  logic [sjf_pkg::SUM_W-1:0]      total_turnaround;
  logic [sjf_pkg::QCOUNT_W-1:0]   queue_count;

  modport source (output valid, status, cpu_busy, running_id, units_done, job_finished,
                  turnaround, waiting, slot_time, completed_count, total_waiting,
                  total_turnaround, queue_count, input ready);
  modport sink   (input valid, status, cpu_busy, running_id, units_done, job_finished,
                  turnaround, waiting, slot_time, completed_count, total_waiting,
                  total_turnaround, queue_count, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/sjf_cell.sv
// One slot of the sorted ready queue: holds a job, inserts or shifts with neighbors.
// Depends on sjf_pkg for job_t and cell_op_t.
`timescale 1ns / 1ps
`default_nettype none

module sjf_cell (
  input  wire logic             clk,
  input  wire sjf_pkg::cell_op_t op,
  input  wire sjf_pkg::job_t    new_job,
  input  wire sjf_pkg::job_t    left_job,
  input  wire sjf_pkg::job_t    right_job,
  input  wire logic             left_le,
  input  wire logic             occ,
  output sjf_pkg::job_t         job_q,
  output logic                  le_o
);

  sjf_pkg::job_t job_r;
  sjf_pkg::job_t job_nxt;

  // this job stays ahead of the new one (ties keep arrival order)
  assign le_o  = occ && (job_r.burst <= new_job.burst);
  assign job_q = job_r;

  // pick hold, take new word, take left neighbor or take right neighbor
  always_comb begin
    job_nxt = job_r;
    case (op)
      sjf_pkg::CELL_HOLD: job_nxt = job_r;
      sjf_pkg::CELL_INSERT: begin
        if (le_o) begin
          job_nxt = job_r;
        end else if (left_le) begin
          job_nxt = new_job;
        end else begin
          job_nxt = left_job;
        end
      end
      sjf_pkg::CELL_SHIFT: job_nxt = right_job;
      default: job_nxt = job_r;
    endcase
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
  end

endmodule

`default_nettype wire

// File: hw/rtl/sjf_queue.sv
// Row of sjf_cell slots forming the burst-sorted ready queue; slot 0 is the head.
// Depends on sjf_pkg and sjf_cell.
`timescale 1ns / 1ps
`default_nettype none

module sjf_queue (
  input  wire logic                       clk,
  input  wire sjf_pkg::cell_op_t          op,
  input  wire sjf_pkg::job_t              new_job,
  input  wire logic [sjf_pkg::FILL_W-1:0] fill,
  output sjf_pkg::job_t                   head_job
);

  sjf_pkg::job_t jobs [sjf_pkg::QUEUE_DEPTH];
  logic          le   [sjf_pkg::QUEUE_DEPTH];

  // chain the slots; head sees "all before me" on its left
  for (genvar i = 0; i < sjf_pkg::QUEUE_DEPTH; i++) begin : g_cell
    sjf_pkg::job_t left_job;
    sjf_pkg::job_t right_job;
    logic          left_le;
    logic          occ;

    assign occ = (sjf_pkg::FILL_W'(i) < fill);

    if (i == 0) begin : g_first
      assign left_job = new_job;
      assign left_le  = 1'b1;
    end else begin : g_mid
      assign left_job = jobs[i-1];
      assign left_le  = le[i-1];
    end

    if (i == sjf_pkg::QUEUE_DEPTH - 1) begin : g_last
      assign right_job = jobs[i];
    end else begin : g_notlast
      assign right_job = jobs[i+1];
    end

    sjf_cell u_cell (
      .clk       (clk),
      .op        (op),
      .new_job   (new_job),
      .left_job  (left_job),
      .right_job (right_job),
      .left_le   (left_le),
      .occ       (occ),
      .job_q     (jobs[i]),
      .le_o      (le[i])
    );
  end

  assign head_job = jobs[0];

endmodule

`default_nettype wire

// File: hw/rtl/shortest_job_first_scheduler_core.sv
// Top level of the non-preemptive shortest-job-first scheduler.
// Depends on sjf_pkg, sjf_if (channel interfaces) and sjf_queue.
//
// Usage:
//   in_ch carries one word per item: command (arrive or tick), job_id and
//   burst_length. out_ch returns exactly one result word per input word.
//   An arrival is inserted into a burst-sorted row of queue slots behind any
//   job of equal burst; a tick dispatches the head if the CPU is idle, runs
//   one slot and reports completion, turnaround, waiting and saturating totals.
// Latency and throughput:
//   A word is processed in the cycle it is accepted: every queue slot compares
//   its burst against the new word in parallel and the row inserts or shifts in
//   that same edge, which also loads the output register. The result word is
//   valid on out_ch in the cycle after acceptance.
//   One word per cycle is sustained while the receiver keeps ready high.
// Stall:
//   in_ch.ready is high when the output register is empty or being drained, so
//   a stalled receiver holds one finished word and blocks further input.
// Reset:
//   rst_n (synchronous, active low) clears time, queue fill, the running job
//   and all counters; queue slot contents are not cleared and need no sweep.
`timescale 1ns / 1ps
`default_nettype none

module shortest_job_first_scheduler_core (
  input  wire logic  clk,
  input  wire logic  rst_n,
  sjf_in_if.sink     in_ch,
  sjf_out_if.source  out_ch
);

  localparam int TW = sjf_pkg::TIME_WIDTH;

  // architectural state
  logic [TW-1:0]                  time_r, time_nxt;
  logic [sjf_pkg::FILL_W-1:0]     fill_r, fill_nxt;
  logic                           run_active_r, run_active_nxt;
  sjf_pkg::job_t                  run_job_r, run_job_nxt;
  logic [sjf_pkg::BURST_W-1:0]    elapsed_r, elapsed_nxt;
  logic [TW-1:0]                  run_wait_r, run_wait_nxt;
  logic [sjf_pkg::COUNT_W-1:0]    done_r, done_nxt;
  logic [sjf_pkg::SUM_W-1:0]      wait_sum_r, wait_sum_nxt;
  logic [sjf_pkg::SUM_W-1:0]      turn_sum_r, turn_sum_nxt;

  // output register
  logic                           out_valid_r, out_valid_nxt;
  sjf_pkg::result_t               out_r, out_nxt;

  logic                           in_ready_int;
  logic                           in_acc;
  sjf_pkg::cell_op_t              q_op;
  sjf_pkg::job_t                  new_job;
  sjf_pkg::job_t                  head_job;

  logic                           dispatch;
  sjf_pkg::job_t                  cur_job;
  logic [sjf_pkg::BURST_W-1:0]    cur_elapsed;
  logic [TW-1:0]                  cur_wait;
  logic [TW-1:0]                  turn;
  logic                           fin;
  logic [sjf_pkg::SUM_W:0]        wsum_ext;
  logic [sjf_pkg::SUM_W:0]        tsum_ext;

  assign in_ready_int = !out_valid_r || out_ch.ready;
  assign in_ch.ready = in_ready_int;
  assign in_acc      = in_ch.valid && in_ready_int;

  assign new_job.id      = in_ch.job_id;
  assign new_job.burst   = in_ch.burst_length;
  assign new_job.arrival = time_r;

  sjf_queue u_queue (
    .clk      (clk),
    .op       (q_op),
    .new_job  (new_job),
    .fill     (fill_r),
    .head_job (head_job)
  );

  // running job as seen in this slot, after a possible dispatch
  assign dispatch    = !run_active_r && (fill_r != '0);
  assign cur_job     = dispatch ? head_job : run_job_r;
  assign cur_elapsed = (dispatch ? '0 : elapsed_r) + sjf_pkg::BURST_W'(1);
  assign cur_wait    = dispatch ? (time_r - head_job.arrival) : run_wait_r;
  assign fin         = (run_active_r || dispatch) && (cur_elapsed >= cur_job.burst);
  assign turn        = time_r + TW'(1) - cur_job.arrival;
  assign wsum_ext    = {1'b0, wait_sum_r} + (sjf_pkg::SUM_W + 1)'(cur_wait);
  assign tsum_ext    = {1'b0, turn_sum_r} + (sjf_pkg::SUM_W + 1)'(turn);

  // advance state and build the result word
  always_comb begin
    time_nxt       = time_r;
    fill_nxt       = fill_r;
    run_active_nxt = run_active_r;
    run_job_nxt    = run_job_r;
    elapsed_nxt    = elapsed_r;
    run_wait_nxt   = run_wait_r;
    done_nxt       = done_r;
    wait_sum_nxt   = wait_sum_r;
    turn_sum_nxt   = turn_sum_r;
    q_op           = sjf_pkg::CELL_HOLD;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;

    if (in_acc) begin
      out_valid_nxt = 1'b1;
      out_nxt       = '0;
      out_nxt.slot_time = sjf_pkg::OUT_TIME_W'(time_r);
      if (in_ch.command == sjf_pkg::CMD_ARRIVE) begin
        if (in_ch.burst_length == '0) begin
          out_nxt.status = sjf_pkg::ST_ZERO;
        end else if (fill_r == sjf_pkg::FILL_W'(sjf_pkg::QUEUE_DEPTH)) begin
          out_nxt.status = sjf_pkg::ST_FULL;
        end else begin
          out_nxt.status = sjf_pkg::ST_ACCEPT;
          q_op           = sjf_pkg::CELL_INSERT;
          fill_nxt       = fill_r + sjf_pkg::FILL_W'(1);
        end
      end else begin
        out_nxt.status = sjf_pkg::ST_TICK;
        time_nxt       = time_r + TW'(1);
        if (dispatch) begin
          q_op     = sjf_pkg::CELL_SHIFT;
          fill_nxt = fill_r - sjf_pkg::FILL_W'(1);
        end
        if (run_active_r || dispatch) begin
          run_active_nxt     = !fin;
          run_job_nxt        = cur_job;
          elapsed_nxt        = cur_elapsed;
          run_wait_nxt       = cur_wait;
          out_nxt.cpu_busy   = 1'b1;
          out_nxt.running_id = cur_job.id;
          out_nxt.units_done = cur_elapsed;
          if (fin) begin
            out_nxt.job_finished = 1'b1;
            out_nxt.turnaround   = sjf_pkg::OUT_TIME_W'(turn);
            out_nxt.waiting      = sjf_pkg::OUT_TIME_W'(cur_wait);
            if (done_r != '1) begin
              done_nxt = done_r + sjf_pkg::COUNT_W'(1);
            end
            wait_sum_nxt = wsum_ext[sjf_pkg::SUM_W] ? '1 : wsum_ext[sjf_pkg::SUM_W-1:0];
            turn_sum_nxt = tsum_ext[sjf_pkg::SUM_W] ? '1 : tsum_ext[sjf_pkg::SUM_W-1:0];
          end
        end
      end
      out_nxt.completed_count  = done_nxt;
      out_nxt.total_waiting    = wait_sum_nxt;
      out_nxt.total_turnaround = turn_sum_nxt;
      out_nxt.queue_count      = sjf_pkg::QCOUNT_W'(fill_nxt);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r       <= '0;
      fill_r       <= '0;
      run_active_r <= 1'b0;
      run_job_r    <= '0;
      elapsed_r    <= '0;
      run_wait_r   <= '0;
      done_r       <= '0;
      wait_sum_r   <= '0;
      turn_sum_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      time_r       <= time_nxt;
      fill_r       <= fill_nxt;
      run_active_r <= run_active_nxt;
      run_job_r    <= run_job_nxt;
      elapsed_r    <= elapsed_nxt;
      run_wait_r   <= run_wait_nxt;
      done_r       <= done_nxt;
      wait_sum_r   <= wait_sum_nxt;
      turn_sum_r   <= turn_sum_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  // drive the result channel
  assign out_ch.valid            = out_valid_r;
  assign out_ch.status           = out_r.status;
  assign out_ch.cpu_busy         = out_r.cpu_busy;
  assign out_ch.running_id       = out_r.running_id;
  assign out_ch.units_done       = out_r.units_done;
  assign out_ch.job_finished     = out_r.job_finished;
  assign out_ch.turnaround       = out_r.turnaround;
  assign out_ch.waiting          = out_r.waiting;
  assign out_ch.slot_time        = out_r.slot_time;
  assign out_ch.completed_count  = out_r.completed_count;
  assign out_ch.total_waiting    = out_r.total_waiting;
  assign out_ch.total_turnaround = out_r.total_turnaround;
  assign out_ch.queue_count      = out_r.queue_count;

  // checks
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= sjf_pkg::FILL_W'(sjf_pkg::QUEUE_DEPTH))
    else $error("queue fill beyond depth");

  a_word_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("accepted word produced no result");

  a_tick_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_ch.command == sjf_pkg::CMD_TICK) |=> time_r == $past(time_r) + TW'(1))
    else $error("tick did not advance time");

  a_fin_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.job_finished |-> out_r.cpu_busy && (out_r.status == sjf_pkg::ST_TICK))
    else $error("finish reported without a running job");

  a_arrive_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_ch.command == sjf_pkg::CMD_ARRIVE) |=> $stable(time_r))
    else $error("arrival moved time");

endmodule

`default_nettype wire

// File: bench/sjf_tb_pkg.sv
// Scoreboard for the shortest-job-first scheduler bench: predicts the result
// word of every accepted input word and checks the words the block returns.
// Depends on sjf_pkg for field widths, status codes and the result layout.
`timescale 1ns / 1ps

package sjf_tb_pkg;

  class sched_scoreboard;

    // predicted scheduler state
    sjf_pkg::job_t                  ready_row [sjf_pkg::QUEUE_DEPTH];
    int unsigned                    row_fill;
    logic [sjf_pkg::TIME_WIDTH-1:0] now_slot;
    bit                             running;
    logic [sjf_pkg::ID_W-1:0]       cur_id;
    logic [sjf_pkg::BURST_W-1:0]    cur_burst;
    logic [sjf_pkg::BURST_W-1:0]    cur_units;
    logic [sjf_pkg::TIME_WIDTH-1:0] cur_arrival;
    logic [sjf_pkg::TIME_WIDTH-1:0] cur_wait;
    logic [sjf_pkg::COUNT_W-1:0]    finished_jobs;
    logic [sjf_pkg::SUM_W-1:0]      wait_total;
    logic [sjf_pkg::SUM_W-1:0]      turn_total;

    sjf_pkg::result_t expected_results [$];
    int unsigned      mismatches;

    function new();
      row_fill      = 0;
      now_slot      = '0;
      running       = 1'b0;
      cur_id        = '0;
      cur_burst     = '0;
      cur_units     = '0;
      cur_arrival   = '0;
      cur_wait      = '0;
      finished_jobs = '0;
      wait_total    = '0;
      turn_total    = '0;
      mismatches    = 0;
    endfunction

    function bit cpu_idle();
      return (row_fill == 0) && !running;
    endfunction

    function int unsigned outstanding();
      return expected_results.size();
    endfunction

    // Add with clamp at the top of the 32-bit range.
    function logic [sjf_pkg::SUM_W-1:0] sat_sum(logic [sjf_pkg::SUM_W-1:0] acc,
                                                logic [sjf_pkg::OUT_TIME_W-1:0] add);
      logic [sjf_pkg::SUM_W:0] total;
      total = {1'b0, acc} + add;
      return total[sjf_pkg::SUM_W] ? {sjf_pkg::SUM_W{1'b1}} : total[sjf_pkg::SUM_W-1:0];
    endfunction

    // Advance the predicted state by one accepted word and queue its result.
    function void predict_word(logic cmd, logic [sjf_pkg::ID_W-1:0] id,
                               logic [sjf_pkg::BURST_W-1:0] burst);
      sjf_pkg::result_t r;
      int               pos;
      r           = '0;
      r.slot_time = now_slot;
      if (cmd == sjf_pkg::CMD_ARRIVE) begin
        if (burst == '0) begin
          r.status = sjf_pkg::ST_ZERO;
        end else if (row_fill >= sjf_pkg::QUEUE_DEPTH) begin
          r.status = sjf_pkg::ST_FULL;
        end else begin
          // insert behind every queued job of equal or shorter burst
          pos = 0;
          while (pos < row_fill && ready_row[pos].burst <= burst) pos++;
          for (int k = row_fill; k > pos; k--) ready_row[k] = ready_row[k-1];
          ready_row[pos].id      = id;
          ready_row[pos].burst   = burst;
          ready_row[pos].arrival = now_slot;
          row_fill++;
          r.status = sjf_pkg::ST_ACCEPT;
        end
      end else begin
        r.status = sjf_pkg::ST_TICK;
        // dispatch the head when the CPU is free
        if (!running && row_fill > 0) begin
          cur_id      = ready_row[0].id;
          cur_burst   = ready_row[0].burst;
          cur_arrival = ready_row[0].arrival;
          cur_wait    = now_slot - cur_arrival;
          cur_units   = '0;
          running     = 1'b1;
          for (int k = 0; k + 1 < row_fill; k++) ready_row[k] = ready_row[k+1];
          row_fill--;
        end
        // run one slot of the current job
        if (running) begin
          cur_units++;
          r.cpu_busy   = 1'b1;
          r.running_id = cur_id;
          r.units_done = cur_units;
          if (cur_units >= cur_burst) begin
            r.job_finished = 1'b1;
            r.turnaround   = now_slot + 1'b1 - cur_arrival;
            r.waiting      = cur_wait;
            if (finished_jobs != {sjf_pkg::COUNT_W{1'b1}}) finished_jobs++;
            wait_total = sat_sum(wait_total, r.waiting);
            turn_total = sat_sum(turn_total, r.turnaround);
            running    = 1'b0;
          end
        end
        now_slot++;
      end
      r.completed_count  = finished_jobs;
      r.total_waiting    = wait_total;
      r.total_turnaround = turn_total;
      r.queue_count      = sjf_pkg::QCOUNT_W'(row_fill);
      expected_results.push_back(r);
    endfunction

    function void check_field(string name, logic [sjf_pkg::SUM_W-1:0] want,
                              logic [sjf_pkg::SUM_W-1:0] got);
      if (got !== want) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    // Compare a returned word with the oldest prediction.
    function void check_result(sjf_pkg::result_t got);
      sjf_pkg::result_t want;
      if (expected_results.size() == 0) begin
        mismatches++;
        $display("%0t: result word with none expected, expected nothing, actual %h",
                 $time, got);
        return;
      end
      want = expected_results.pop_front();
      check_field("status",           want.status,           got.status);
      check_field("cpu_busy",         want.cpu_busy,         got.cpu_busy);
      check_field("running_id",       want.running_id,       got.running_id);
      check_field("units_done",       want.units_done,       got.units_done);
      check_field("job_finished",     want.job_finished,     got.job_finished);
      check_field("turnaround",       want.turnaround,       got.turnaround);
      check_field("waiting",          want.waiting,          got.waiting);
      check_field("slot_time",        want.slot_time,        got.slot_time);
      check_field("completed_count",  want.completed_count,  got.completed_count);
      check_field("total_waiting",    want.total_waiting,    got.total_waiting);
      check_field("total_turnaround", want.total_turnaround, got.total_turnaround);
      check_field("queue_count",      want.queue_count,      got.queue_count);
    endfunction

  endclass

endpackage

// File: bench/tb_top.sv
// Top of the scheduler bench: clock, reset, input driver, result monitor and
// stimulus phases. Depends on sjf_pkg, sjf_if, sjf_tb_pkg and the block itself.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned PHASE_WORDS = 584;
  localparam int unsigned SEGMENT_LEN = 64;

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned cycle_count = 0;

  sjf_tb_pkg::sched_scoreboard board;

  sjf_in_if  in_ch ();
  sjf_out_if out_ch ();

  shortest_job_first_scheduler_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #10 clk = ~clk;

  // Bound the run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("shortest_job_first_scheduler_core test failed");
      $finish;
    end
  end

  // Stall the result channel at random.
  always @(negedge clk) begin
    out_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  // Check every accepted result word.
  always @(posedge clk) begin : watch_results
    sjf_pkg::result_t got;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.status           = sjf_pkg::status_t'(out_ch.status);
      got.cpu_busy         = out_ch.cpu_busy;
      got.running_id       = out_ch.running_id;
      got.units_done       = out_ch.units_done;
      got.job_finished     = out_ch.job_finished;
      got.turnaround       = out_ch.turnaround;
      got.waiting          = out_ch.waiting;
      got.slot_time        = out_ch.slot_time;
      got.completed_count  = out_ch.completed_count;
      got.total_waiting    = out_ch.total_waiting;
      got.total_turnaround = out_ch.total_turnaround;
      got.queue_count      = out_ch.queue_count;
      board.check_result(got);
    end
  end

  // Present one word, idling first at random, and hold it until accepted.
  task automatic send_word(logic cmd, logic [sjf_pkg::ID_W-1:0] id,
                           logic [sjf_pkg::BURST_W-1:0] burst);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.command      <= cmd;
    in_ch.job_id       <= id;
    in_ch.burst_length <= burst;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    board.predict_word(cmd, id, burst);
  endtask

  // Hold off the sender until every predicted word has come back.
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
  endtask

  // Random words in segments that fill, drain or mix the queue.
  task automatic random_phase(int unsigned send_pct, int unsigned recv_pct);
    int unsigned                 arrive_pct;
    int unsigned                 pick;
    logic                        cmd;
    logic [sjf_pkg::BURST_W-1:0] burst;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int n = 0; n < PHASE_WORDS; n++) begin
      if (n % SEGMENT_LEN == 0) begin
        case ($urandom_range(2))
          0: arrive_pct = 90;
          1: arrive_pct = 15;
          default: arrive_pct = 50;
        endcase
      end
      cmd  = ($urandom_range(99) < arrive_pct) ? sjf_pkg::CMD_ARRIVE : sjf_pkg::CMD_TICK;
      pick = $urandom_range(99);
      if (pick < 6)       burst = '0;
      else if (pick < 12) burst = sjf_pkg::BURST_W'($urandom_range(255, 200));
      else if (pick < 20) burst = sjf_pkg::BURST_W'($urandom_range(255));
      else                burst = sjf_pkg::BURST_W'($urandom_range(8, 1));
      send_word(cmd, sjf_pkg::ID_W'($urandom_range(255)), burst);
      if ($urandom_range(199) == 0) drain_results();
    end
  endtask

  initial begin
    board              = new();
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.command      = sjf_pkg::CMD_ARRIVE;
    in_ch.job_id       = '0;
    in_ch.burst_length = '0;
    out_ch.ready       = 1'b0;
    send_idle_pct      = 0;
    recv_idle_pct      = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: idle tick, zero bursts, field extremes, equal-burst order.
    send_word(sjf_pkg::CMD_TICK,   8'h00, 8'h00);
    send_word(sjf_pkg::CMD_ARRIVE, 8'h00, 8'h00);
    send_word(sjf_pkg::CMD_ARRIVE, 8'hFF, 8'h00);
    send_word(sjf_pkg::CMD_ARRIVE, 8'hAA, 8'hFF);
    send_word(sjf_pkg::CMD_ARRIVE, 8'h55, 8'h01);
    send_word(sjf_pkg::CMD_ARRIVE, 8'h01, 8'h01);
    send_word(sjf_pkg::CMD_ARRIVE, 8'h02, 8'h03);
    send_word(sjf_pkg::CMD_ARRIVE, 8'hFF, 8'h80);
    send_word(sjf_pkg::CMD_ARRIVE, 8'h03, 8'h03);
    repeat (5) send_word(sjf_pkg::CMD_TICK, 8'hFF, 8'hFF);
    send_word(sjf_pkg::CMD_ARRIVE, 8'h04, 8'h02);
    send_word(sjf_pkg::CMD_ARRIVE, 8'h00, 8'hFF);
    repeat (6) send_word(sjf_pkg::CMD_TICK, 8'h00, 8'h00);

    // Random traffic under three idling patterns.
    random_phase(34, 82);
    random_phase(82, 34);
    random_phase(0, 0);

    drain_results();
    repeat (8) @(posedge clk);
    if (board.mismatches == 0 && board.outstanding() == 0) begin
      $display("shortest_job_first_scheduler_core test passed");
    end else begin
      $display("shortest_job_first_scheduler_core test failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/sjf_pkg.sv
hw/rtl/sjf_if.sv
hw/rtl/sjf_cell.sv
hw/rtl/sjf_queue.sv
hw/rtl/shortest_job_first_scheduler_core.sv
bench/sjf_tb_pkg.sv
bench/tb_top.sv
